FILE: rtl/curl_magnitude_stencil_3d_assert.svh
// assertion macros for the curl magnitude stencil
// used by modules that check their own control logic; no other dependencies
`ifndef CURL_MAGNITUDE_STENCIL_3D_ASSERT_SVH
`define CURL_MAGNITUDE_STENCIL_3D_ASSERT_SVH

// same-cycle implication, checked outside reset
`define CMS_ASSERT_NOW(label, clk, rst, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("cms assertion failed");

// next-cycle implication, checked outside reset
`define CMS_ASSERT_NEXT(label, clk, rst, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("cms assertion failed");

`endif

FILE: rtl/cms_pkg.sv
// shared types and constants of the curl magnitude stencil
// no dependencies; used by the front, queue, back, top level and testbench
`default_nettype none
package cms_pkg;

  localparam int SAMPLE_WIDTH = 16;
  localparam int MAX_SIDE_DEF = 64;
  localparam int MAX_PLANES_DEF = 1024;

  // curl components, magnitudes, squares and root
  localparam int CW = SAMPLE_WIDTH + 2;
  localparam int MAG_W = CW - 1;
  localparam int SQ_W = 2 * MAG_W;
  localparam int SUM_W = SQ_W + 2;
  localparam int ROOT_W = SUM_W / 2;
  localparam int OUT_W = 18;

  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 11;
  localparam logic [CFG_IDX_W-1:0] REG_SIZE_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SIZE_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SIZE_Z = 2'd2;
  localparam logic [10:0] SIZE_X_RST = 11'd64;
  localparam logic [6:0] SIZE_YZ_RST = 7'd64;

  localparam int QUEUE_DEPTH = 2;

  typedef struct packed {
    logic mode;
    logic signed [SAMPLE_WIDTH-1:0] comp_a;
    logic signed [SAMPLE_WIDTH-1:0] comp_b;
    logic signed [SAMPLE_WIDTH-1:0] comp_c;
  } in_item_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] curl_value;
    logic final_voxel;
  } out_item_t;

  // work handed from front to back
  typedef struct packed {
    logic zero;
    logic last;
    logic signed [CW-1:0] cx;
    logic signed [CW-1:0] cy;
    logic signed [CW-1:0] cz;
  } job_t;

endpackage
`default_nettype wire

FILE: rtl/cms_stream_if.sv
// valid/ready stream channel with a typed payload
// payload types come from cms_pkg
`default_nettype none
interface cms_stream_if #(parameter type payload_t = logic);
  logic valid;
  logic ready;
  payload_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface
`default_nettype wire

FILE: rtl/cms_front.sv
// front end: position tracking, plane store and curl differences
// depends on cms_pkg and cms_stream_if
`default_nettype none
module cms_front #(
  parameter int MAX_SIDE = cms_pkg::MAX_SIDE_DEF,
  parameter int MAX_PLANES = cms_pkg::MAX_PLANES_DEF
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic cfg_we,
  input  wire logic [cms_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [cms_pkg::CFG_DATA_W-1:0] cfg_data,
  cms_stream_if.sink in_item,
  output cms_pkg::job_t q_data,
  output logic q_valid,
  input  wire logic q_ready
);

  localparam int SW = cms_pkg::SAMPLE_WIDTH;
  localparam int CW = cms_pkg::CW;
  localparam int SIDE_W = $clog2(MAX_SIDE);
  localparam int SC_W = $clog2(MAX_SIDE + 1);
  localparam int PL_W = $clog2(MAX_PLANES);
  localparam int PLC_W = $clog2(MAX_PLANES + 1);
  localparam int FC_W = $clog2(MAX_SIDE * MAX_SIDE);
  localparam int PN_W = $clog2(MAX_SIDE * MAX_SIDE + 1);
  localparam int DEPTH = 2 * MAX_SIDE * MAX_SIDE;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int NOPS = 5;
  localparam int OPI_W = $clog2(NOPS);
  localparam int RC_W = $clog2(NOPS + 1);
  // operand slots, in read order
  localparam logic [RC_W-1:0] OP_KP = RC_W'(0);
  localparam logic [RC_W-1:0] OP_KM = RC_W'(1);
  localparam logic [RC_W-1:0] OP_JP = RC_W'(2);
  localparam logic [RC_W-1:0] OP_JM = RC_W'(3);
  localparam logic [RC_W-1:0] OP_IM = RC_W'(4);
  localparam logic [RC_W-1:0] RD_END = RC_W'(NOPS);

  typedef enum logic [2:0] {
    F_IDLE  = 3'b001,
    F_READ  = 3'b010,
    F_WRITE = 3'b100
  } fstate_t;

  fstate_t state;
  logic [10:0] size_x;
  logic [6:0] size_y, size_z;
  logic [PLC_W-1:0] nx;
  logic [SC_W-1:0] ny, nz;
  logic [PN_W-1:0] plane_n;
  logic [31:0] sx32, sy32, sz32;

  logic [PL_W-1:0] ic;
  logic [SIDE_W-1:0] cj, ck;
  logic in_done;
  logic [FC_W-1:0] fcnt;

  cms_pkg::in_item_t it;
  logic [SIDE_W-1:0] lj, lk;
  logic lpar, has_res, do_write, zero_l, last_l;
  logic [RC_W-1:0] rd_cnt;
  logic [3*SW-1:0] ops [NOPS];

  logic [3*SW-1:0] mem [DEPTH];
  logic [3*SW-1:0] rdata;
  logic [ADDR_W-1:0] raddr, waddr;
  logic we;

  logic acc, last_k, last_j, last_i, interior, fin;

  function automatic logic [ADDR_W-1:0] addr_of(input logic p, input logic [SIDE_W-1:0] jj,
                                                 input logic [SIDE_W-1:0] kk);
    return ADDR_W'(p) * ADDR_W'(MAX_SIDE * MAX_SIDE) + ADDR_W'(jj) * ADDR_W'(MAX_SIDE)
           + ADDR_W'(kk);
  endfunction

  // saturated sizes
  always_comb begin
    sx32 = 32'(size_x);
    sy32 = 32'(size_y);
    sz32 = 32'(size_z);
    nx = (sx32 < 32'd3) ? PLC_W'(3) :
         (sx32 > 32'(MAX_PLANES)) ? PLC_W'(MAX_PLANES) : PLC_W'(sx32);
    ny = (sy32 < 32'd3) ? SC_W'(3) :
         (sy32 > 32'(MAX_SIDE)) ? SC_W'(MAX_SIDE) : SC_W'(sy32);
    nz = (sz32 < 32'd3) ? SC_W'(3) :
         (sz32 > 32'(MAX_SIDE)) ? SC_W'(MAX_SIDE) : SC_W'(sz32);
    plane_n = PN_W'(ny) * PN_W'(nz);
  end

  assign in_item.ready = (state == F_IDLE);
  assign acc = in_item.valid && in_item.ready;

  assign last_k = (SC_W'(ck) + SC_W'(1)) == nz;
  assign last_j = (SC_W'(cj) + SC_W'(1)) == ny;
  assign last_i = (PLC_W'(ic) + PLC_W'(1)) == nx;
  assign fin = (PN_W'(fcnt) + PN_W'(1)) == plane_n;
  assign interior = (PLC_W'(ic) >= PLC_W'(2)) && (cj != '0) && ((SC_W'(cj) + SC_W'(1)) < ny)
                    && (ck != '0) && ((SC_W'(ck) + SC_W'(1)) < nz);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
      size_x <= cms_pkg::SIZE_X_RST;
      size_y <= cms_pkg::SIZE_YZ_RST;
      size_z <= cms_pkg::SIZE_YZ_RST;
      ic <= '0;
      cj <= '0;
      ck <= '0;
      in_done <= 1'b0;
      fcnt <= '0;
      rd_cnt <= '0;
    end else begin
      if (cfg_we && (cfg_index == cms_pkg::REG_SIZE_X || cfg_index == cms_pkg::REG_SIZE_Y ||
                     cfg_index == cms_pkg::REG_SIZE_Z)) begin
        if (cfg_index == cms_pkg::REG_SIZE_X) size_x <= cfg_data;
        if (cfg_index == cms_pkg::REG_SIZE_Y) size_y <= cfg_data[6:0];
        if (cfg_index == cms_pkg::REG_SIZE_Z) size_z <= cfg_data[6:0];
        ic <= '0;
        cj <= '0;
        ck <= '0;
        in_done <= 1'b0;
        fcnt <= '0;
      end
      unique case (state)
        F_IDLE: begin
          if (acc && in_item.data.mode && in_done) begin
            // flush: last plane is a face, so a zero result
            if (fin) begin
              ic <= '0;
              cj <= '0;
              ck <= '0;
              in_done <= 1'b0;
              fcnt <= '0;
            end else begin
              fcnt <= fcnt + FC_W'(1);
            end
            state <= F_WRITE;
          end else if (acc && !in_item.data.mode && !in_done) begin
            if (last_k) begin
              ck <= '0;
              if (last_j) begin
                cj <= '0;
                if (last_i) in_done <= 1'b1;
                else ic <= ic + PL_W'(1);
              end else begin
                cj <= cj + SIDE_W'(1);
              end
            end else begin
              ck <= ck + SIDE_W'(1);
            end
            rd_cnt <= '0;
            state <= interior ? F_READ : F_WRITE;
          end
        end
        F_READ: begin
          rd_cnt <= rd_cnt + RC_W'(1);
          if (rd_cnt == RD_END) state <= F_WRITE;
        end
        F_WRITE: begin
          if (!has_res || q_ready) state <= F_IDLE;
        end
        default: state <= F_IDLE;
      endcase
    end
  end

  // item latch
  always_ff @(posedge clk) begin
    if (acc) begin
      it <= in_item.data;
      lj <= cj;
      lk <= ck;
      lpar <= ic[0];
      if (in_item.data.mode) begin
        has_res <= 1'b1;
        do_write <= 1'b0;
        zero_l <= 1'b1;
        last_l <= fin;
      end else begin
        has_res <= (ic != '0);
        do_write <= 1'b1;
        zero_l <= !interior;
        last_l <= 1'b0;
      end
    end
    if (state == F_READ && rd_cnt != '0) ops[OPI_W'(rd_cnt - RC_W'(1))] <= rdata;
  end

  // in-plane neighbors of the finished voxel sit in the other parity plane, its lower one in this
  always_comb begin
    unique case (rd_cnt)
      OP_KP: raddr = addr_of(!lpar, lj, lk + SIDE_W'(1));
      OP_KM: raddr = addr_of(!lpar, lj, lk - SIDE_W'(1));
      OP_JP: raddr = addr_of(!lpar, lj + SIDE_W'(1), lk);
      OP_JM: raddr = addr_of(!lpar, lj - SIDE_W'(1), lk);
      OP_IM: raddr = addr_of(lpar, lj, lk);
      default: raddr = addr_of(lpar, lj, lk);
    endcase
  end

  assign we = (state == F_WRITE) && do_write;
  assign waddr = addr_of(lpar, lj, lk);

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= {it.comp_c, it.comp_b, it.comp_a};
    rdata <= mem[raddr];
  end

  // central differences; word layout is {c, b, a}
  always_comb begin
    q_data.zero = zero_l;
    q_data.last = last_l;
    q_data.cx = (CW'($signed(ops[OP_JP][3*SW-1:2*SW])) - CW'($signed(ops[OP_JM][3*SW-1:2*SW])))
              - (CW'($signed(ops[OP_KP][2*SW-1:SW])) - CW'($signed(ops[OP_KM][2*SW-1:SW])));
    q_data.cy = (CW'($signed(ops[OP_KP][SW-1:0])) - CW'($signed(ops[OP_KM][SW-1:0])))
              - (CW'(it.comp_c) - CW'($signed(ops[OP_IM][3*SW-1:2*SW])));
    q_data.cz = (CW'(it.comp_b) - CW'($signed(ops[OP_IM][2*SW-1:SW])))
              - (CW'($signed(ops[OP_JP][SW-1:0])) - CW'($signed(ops[OP_JM][SW-1:0])));
  end

  assign q_valid = (state == F_WRITE) && has_res;

endmodule
`default_nettype wire

FILE: rtl/cms_queue.sv
// short job queue between front and back
// depends on cms_pkg and the assertion macro header
`default_nettype none
`include "curl_magnitude_stencil_3d_assert.svh"
module cms_queue (
  input  wire logic clk,
  input  wire logic rst,
  input  wire cms_pkg::job_t push_data,
  input  wire logic push_valid,
  output logic push_ready,
  output cms_pkg::job_t pop_data,
  output logic pop_valid,
  input  wire logic pop_ready
);

  localparam int QD = cms_pkg::QUEUE_DEPTH;
  localparam int PTR_W = $clog2(QD);
  localparam int CNT_W = $clog2(QD + 1);

  cms_pkg::job_t slots [QD];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;
  logic push, pop;

  assign push_ready = (count != CNT_W'(QD));
  assign pop_valid = (count != '0);
  assign push = push_valid && push_ready;
  assign pop = pop_valid && pop_ready;
  assign pop_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == PTR_W'(QD - 1)) ? '0 : wr_ptr + PTR_W'(1);
      if (pop) rd_ptr <= (rd_ptr == PTR_W'(QD - 1)) ? '0 : rd_ptr + PTR_W'(1);
      if (push && !pop) count <= count + CNT_W'(1);
      else if (pop && !push) count <= count - CNT_W'(1);
    end
  end

  `CMS_ASSERT_NOW(a_count_bound, clk, rst, 1'b1, count <= CNT_W'(QD))
  `CMS_ASSERT_NEXT(a_count_up, clk, rst, push && !pop, count == $past(count) + CNT_W'(1))
  `CMS_ASSERT_NEXT(a_count_down, clk, rst, pop && !push, count == $past(count) - CNT_W'(1))
  `CMS_ASSERT_NOW(a_ptrs_empty, clk, rst, count == '0, wr_ptr == rd_ptr)

endmodule
`default_nettype wire

FILE: rtl/cms_back.sv
// back end: sum of squares, bit-serial square root, signed result register
// depends on cms_pkg and cms_stream_if
`default_nettype none
module cms_back (
  input  wire logic clk,
  input  wire logic rst,
  input  wire cms_pkg::job_t job,
  input  wire logic job_valid,
  output logic job_ready,
  cms_stream_if.source out_item
);

  localparam int CW = cms_pkg::CW;
  localparam int MAG_W = cms_pkg::MAG_W;
  localparam int SQ_W = cms_pkg::SQ_W;
  localparam int SUM_W = cms_pkg::SUM_W;
  localparam int ROOT_W = cms_pkg::ROOT_W;
  localparam int REM_W = ROOT_W + 3;
  localparam int OUT_W = cms_pkg::OUT_W;
  localparam int IT_W = $clog2(ROOT_W);

  typedef enum logic [3:0] {
    B_IDLE = 4'b0001,
    B_SQ   = 4'b0010,
    B_ROOT = 4'b0100,
    B_OUT  = 4'b1000
  } bstate_t;

  bstate_t state;
  logic [1:0] sq_cnt;
  logic [IT_W-1:0] it_cnt;
  logic [MAG_W-1:0] ax, ay, az, mop;
  logic [SQ_W-1:0] sq;
  logic [SUM_W-1:0] rad;
  logic [REM_W-1:0] rem, rem_sh, trial;
  logic [ROOT_W-1:0] root;
  logic zero_l, last_l, neg_l;
  logic [OUT_W-1:0] mag;
  logic out_free;

  function automatic logic [MAG_W-1:0] absv(input logic signed [CW-1:0] v);
    return v[CW-1] ? MAG_W'(-v) : MAG_W'(v);
  endfunction

  assign job_ready = (state == B_IDLE);
  assign out_free = !out_item.valid || out_item.ready;

  always_comb begin
    unique case (sq_cnt)
      2'd0: mop = ax;
      2'd1: mop = ay;
      default: mop = az;
    endcase
    sq = SQ_W'(mop) * SQ_W'(mop);
    rem_sh = {rem[REM_W-3:0], rad[SUM_W-1:SUM_W-2]};
    trial = REM_W'({root, 2'b01});
    mag = OUT_W'(root >> 1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
      out_item.valid <= 1'b0;
    end else begin
      if (state == B_OUT && out_free) out_item.valid <= 1'b1;
      else if (out_item.ready) out_item.valid <= 1'b0;
      unique case (state)
        B_IDLE: begin
          if (job_valid) state <= job.zero ? B_OUT : B_SQ;
        end
        B_SQ: begin
          if (sq_cnt == 2'd2) state <= B_ROOT;
        end
        B_ROOT: begin
          if (it_cnt == IT_W'(ROOT_W - 1)) state <= B_OUT;
        end
        B_OUT: begin
          if (out_free) state <= B_IDLE;
        end
        default: state <= B_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      B_IDLE: begin
        ax <= absv(job.cx);
        ay <= absv(job.cy);
        az <= absv(job.cz);
        neg_l <= job.cy[CW-1];
        zero_l <= job.zero;
        last_l <= job.last;
        sq_cnt <= 2'd0;
        rad <= '0;
      end
      B_SQ: begin
        rad <= rad + SUM_W'(sq);
        sq_cnt <= sq_cnt + 2'd1;
        rem <= '0;
        root <= '0;
        it_cnt <= '0;
      end
      B_ROOT: begin
        // two radicand bits per step, one root bit out
        rad <= rad << 2;
        it_cnt <= it_cnt + IT_W'(1);
        if (rem_sh >= trial) begin
          rem <= rem_sh - trial;
          root <= {root[ROOT_W-2:0], 1'b1};
        end else begin
          rem <= rem_sh;
          root <= {root[ROOT_W-2:0], 1'b0};
        end
      end
      B_OUT: begin
        if (out_free) begin
          out_item.data.final_voxel <= last_l;
          if (zero_l) out_item.data.curl_value <= '0;
          else out_item.data.curl_value <= neg_l ? $signed(-mag) : $signed(mag);
        end
      end
      default: begin
      end
    endcase
  end

endmodule
`default_nettype wire

FILE: rtl/curl_magnitude_stencil_3d.sv
// top level of the streaming 3d curl magnitude stencil
// depends on cms_pkg, cms_stream_if, cms_front, cms_queue and cms_back
`default_nettype none
// Voxels stream in k fastest, then j, then i; the result of a voxel leaves when the voxel one
// plane later arrives, and flush items drain the last plane once the volume is in. The front
// takes a new item only once it is done with the last one and its job is queued. Interior
// voxels (past the first two planes and off the j and k faces) also need the five reads of
// the single-read-port plane store before their write. The back takes a new job only once
// its result is in the output register: three squares through one multiplier, then an
// 18-step bit-serial square root, or neither for a zero result. A two-entry job queue lets
// front and back stall on their own. The plane store has no clearing pass: only interior
// voxels read it, and their neighbors are always written first. A write to any size register
// restarts the stream.
module curl_magnitude_stencil_3d #(
  parameter int MAX_SIDE = cms_pkg::MAX_SIDE_DEF,
  parameter int MAX_PLANES = cms_pkg::MAX_PLANES_DEF
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic cfg_we,
  input  wire logic [cms_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [cms_pkg::CFG_DATA_W-1:0] cfg_data,
  cms_stream_if.sink in_item,
  cms_stream_if.source out_item
);

  cms_pkg::job_t f_job, b_job;
  logic f_valid, f_ready, b_valid, b_ready;

  cms_front #(.MAX_SIDE(MAX_SIDE), .MAX_PLANES(MAX_PLANES)) u_front (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_item(in_item),
    .q_data(f_job), .q_valid(f_valid), .q_ready(f_ready)
  );

  cms_queue u_queue (
    .clk(clk), .rst(rst),
    .push_data(f_job), .push_valid(f_valid), .push_ready(f_ready),
    .pop_data(b_job), .pop_valid(b_valid), .pop_ready(b_ready)
  );

  cms_back u_back (
    .clk(clk), .rst(rst),
    .job(b_job), .job_valid(b_valid), .job_ready(b_ready),
    .out_item(out_item)
  );

endmodule
`default_nettype wire

FILE: dv/curl_magnitude_stencil_3d_tb.sv
// testbench for the streaming 3d curl magnitude stencil: drives voxel and flush items,
// predicts each result and checks it field by field in order
// depends on cms_pkg, cms_stream_if and curl_magnitude_stencil_3d from the rtl folder
`default_nettype none
module curl_magnitude_stencil_3d_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import cms_pkg::*;

  localparam int SIDE = 64;
  localparam int PLANES = 1024;
  localparam int SETTLE = 60;
  localparam int LIMIT = 1500000;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  class curl_scoreboard;
    longint field_store[2*SIDE*SIDE][3];
    int unsigned in_pos, out_pos;
    int unsigned sx, sy, sz;
    out_item_t curl_expected[$];
    int errors;

    function new();
      in_pos = 0; out_pos = 0; sx = 64; sy = 64; sz = 64; errors = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      if (idx == REG_SIZE_X) sx = val;
      else if (idx == REG_SIZE_Y) sy = val[6:0];
      else if (idx == REG_SIZE_Z) sz = val[6:0];
      else return;
      in_pos = 0; out_pos = 0;
    endfunction

    static function int unsigned clampu(int unsigned v, int unsigned lo, int unsigned hi);
      return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    static function int unsigned slot(int unsigned i, int unsigned j, int unsigned k);
      return ((i & 1) * SIDE + j) * SIDE + k;
    endfunction

    static function longint unsigned floor_root(longint unsigned n);
      longint unsigned r, b;
      r = 0; b = 64'd1 << 62;
      while (b > n) b >>= 2;
      while (b != 0) begin
        if (n >= r + b) begin
          n -= r + b; r = (r >> 1) + b;
        end else begin
          r >>= 1;
        end
        b >>= 2;
      end
      return r;
    endfunction

    function void note(in_item_t it);
      int unsigned nx, ny, nz, plane, total, ic, rem, j, k, here, io;
      longint a, b, c, cx, cy, cz, val, mag;
      longint unsigned ax, ay, az;
      out_item_t r;
      nx = clampu(sx, 3, PLANES); ny = clampu(sy, 3, SIDE); nz = clampu(sz, 3, SIDE);
      plane = ny * nz; total = nx * plane;
      if (it.mode) begin
        if (in_pos < total || out_pos >= total) return;
        r.curl_value = '0;
        r.final_voxel = (out_pos == total - 1);
        curl_expected.push_back(r);
        out_pos++;
        if (out_pos >= total) begin
          in_pos = 0; out_pos = 0;
        end
        return;
      end
      if (in_pos >= total) return;
      ic = in_pos / plane; rem = in_pos % plane; j = rem / nz; k = rem % nz;
      a = it.comp_a; b = it.comp_b; c = it.comp_c;
      here = slot(ic, j, k);
      if (ic >= 1) begin
        io = ic - 1; val = 0;
        if (io >= 1 && j >= 1 && j + 1 < ny && k >= 1 && k + 1 < nz) begin
          cx = (field_store[slot(io, j+1, k)][2] - field_store[slot(io, j-1, k)][2])
             - (field_store[slot(io, j, k+1)][1] - field_store[slot(io, j, k-1)][1]);
          cy = (field_store[slot(io, j, k+1)][0] - field_store[slot(io, j, k-1)][0])
             - (c - field_store[here][2]);
          cz = (b - field_store[here][1])
             - (field_store[slot(io, j+1, k)][0] - field_store[slot(io, j-1, k)][0]);
          ax = cx < 0 ? -cx : cx; ay = cy < 0 ? -cy : cy; az = cz < 0 ? -cz : cz;
          if (ax >= 262144 || ay >= 262144 || az >= 262144) mag = 131072;
          else mag = floor_root(ax*ax + ay*ay + az*az) >> 1;
          if (cy < 0) begin
            if (mag > 131072) mag = 131072;
            val = -mag;
          end else begin
            if (mag > 131071) mag = 131071;
            val = mag;
          end
        end
        r.curl_value = val[OUT_W-1:0];
        r.final_voxel = 1'b0;
        curl_expected.push_back(r);
        out_pos++;
      end
      field_store[here][0] = a; field_store[here][1] = b; field_store[here][2] = c;
      in_pos++;
    endfunction

    function void check(out_item_t got);
      out_item_t want;
      if (curl_expected.size() == 0) begin
        $display("%0t: unexpected result curl_value %0d final_voxel %0b",
                 $time, got.curl_value, got.final_voxel);
        errors++;
        return;
      end
      want = curl_expected.pop_front();
      if (got.curl_value !== want.curl_value) begin
        $display("%0t: curl_value expected %0d actual %0d",
                 $time, want.curl_value, got.curl_value);
        errors++;
      end
      if (got.final_voxel !== want.final_voxel) begin
        $display("%0t: final_voxel expected %0b actual %0b",
                 $time, want.final_voxel, got.final_voxel);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  cms_stream_if #(.payload_t(in_item_t)) in_ch();
  cms_stream_if #(.payload_t(out_item_t)) out_ch();

  curl_scoreboard sb = new();
  bit calm = 1'b0;
  bit hold_req = 1'b0;
  int sent = 0;
  longint cycles = 0;

  initial begin
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    out_ch.ready = 1'b0;
  end

  curl_magnitude_stencil_3d u_dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_item(in_ch), .out_item(out_ch)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("curl_magnitude_stencil_3d verification failed");
      $finish;
    end
  end

  // result side: checks accepted items, stalls in bursts, holds off on request
  initial begin
    int stall_left, hold_left;
    stall_left = 0; hold_left = 0;
    forever begin
      @(posedge clk);
      if (!rst && out_ch.valid && out_ch.ready) sb.check(out_ch.data);
      if (hold_req) begin
        hold_req = 1'b0; hold_left = 400;
      end
      if (hold_left > 0) begin
        hold_left--; out_ch.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--; out_ch.ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(0, 18); out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  task automatic send(logic mode, logic [15:0] a, logic [15:0] b, logic [15:0] c);
    in_item_t it;
    if (!calm && $urandom_range(0, 7) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    it.mode = mode; it.comp_a = a; it.comp_b = b; it.comp_c = c;
    in_ch.valid <= 1'b1;
    in_ch.data <= it;
    do @(posedge clk); while (!in_ch.ready);
    sb.note(it);
    sent++;
  endtask

  task automatic send_voxel();
    send(1'b0, 16'($urandom), 16'($urandom), 16'($urandom));
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (sb.curl_expected.size() > 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= val;
    @(posedge clk);
    sb.write_reg(idx, val);
    cfg_we <= 1'b0;
  endtask

  task automatic set_sizes(int x, int y, int z);
    write_reg(REG_SIZE_X, x[10:0]);
    write_reg(REG_SIZE_Y, y[10:0]);
    write_reg(REG_SIZE_Z, z[10:0]);
  endtask

  // well-formed volume with optional noise, or a broken prefix
  task automatic run_volume(int x, int y, int z, bit broken, bit pause_mid);
    int nx, ny, nz, total, plane, n;
    nx = curl_scoreboard::clampu(x, 3, PLANES);
    ny = curl_scoreboard::clampu(y, 3, SIDE);
    nz = curl_scoreboard::clampu(z, 3, SIDE);
    plane = ny * nz; total = nx * plane;
    set_sizes(x, y, z);
    if (broken) begin
      n = $urandom_range(1, total);
      repeat (n) begin
        if ($urandom_range(0, 5) == 0) send(1'b1, 16'($urandom), 16'($urandom), 16'($urandom));
        else send_voxel();
      end
    end else begin
      for (int v = 0; v < total; v++) begin
        if ($urandom_range(0, 30) == 0) send(1'b1, '0, '0, '0);
        if (pause_mid && v == total / 2) begin
          in_ch.valid <= 1'b0;
          while (sb.curl_expected.size() > 0) @(posedge clk);
        end
        send_voxel();
      end
      if ($urandom_range(0, 3) == 0) send_voxel();
      for (int f = 0; f < plane; f++) send(1'b1, 16'($urandom), 16'($urandom), 16'($urandom));
    end
    drain();
  endtask

  initial begin
    logic [15:0] edge_vals [5];
    int x, y, z;
    edge_vals = '{16'h8000, 16'h7fff, 16'h0000, 16'hffff, 16'h0001};
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: smallest volume with extreme components, early flush, late data
    write_reg(REG_UNUSED, 11'h7ff);
    set_sizes(0, 2, 3);
    send(1'b1, '0, '0, '0);
    for (int v = 0; v < 27; v++)
      send(1'b0, edge_vals[v % 5], edge_vals[(v * 3 + 1) % 5], edge_vals[(v * 2 + 4) % 5]);
    send(1'b0, 16'h7fff, 16'h8000, 16'h7fff);
    for (int f = 0; f < 9; f++) send(1'b1, '0, '0, '0);
    drain();

    // largest sizes: only a partial first plane, so no results
    set_sizes(2047, 127, 127);
    repeat (20) send_voxel();
    drain();
    // largest plane count with small planes, a partial volume only
    set_sizes(1024, 3, 3);
    hold_req = 1'b1;
    repeat (60) send_voxel();
    drain();

    run_volume(4, 4, 4, 1'b0, 1'b1);
    while (sent < 950) begin
      if (sent > 800) calm = 1'b1;
      if ($urandom_range(0, 3) == 0) begin
        x = $urandom_range(7, 12); y = 3; z = $urandom_range(0, 4);
      end else begin
        x = $urandom_range(2, 5); y = $urandom_range(2, 5); z = $urandom_range(3, 6);
      end
      run_volume(x, y, z, $urandom_range(0, 4) == 0, 1'b0);
    end

    drain();
    if (sb.errors == 0 && sb.curl_expected.size() == 0)
      $display("curl_magnitude_stencil_3d verification clean");
    else
      $display("curl_magnitude_stencil_3d verification failed");
    $finish;
  end
endmodule
`default_nettype wire

FILE: curl_magnitude_stencil_3d.f
+incdir+rtl
rtl/cms_pkg.sv
rtl/cms_stream_if.sv
rtl/cms_front.sv
rtl/cms_queue.sv
rtl/cms_back.sv
rtl/curl_magnitude_stencil_3d.sv
dv/curl_magnitude_stencil_3d_tb.sv
